[design/stuffed_packet_receiver_crc16_defines.svh]
`ifndef STUFFED_PACKET_RECEIVER_CRC16_DEFINES_SVH
`define STUFFED_PACKET_RECEIVER_CRC16_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define SPRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stuffed packet receiver: assertion failed");

// next-cycle implication
`define SPRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stuffed packet receiver: assertion failed");

`endif

[design/sprcrc16_pkg.sv]
package sprcrc16_pkg;

   localparam int unsigned MaxParamDefault = 1024;

   localparam logic [15:0] TimeoutReset = 16'd100;
   localparam logic [15:0] CrcPoly      = 16'h8005;

   localparam logic [7:0] ByteFf     = 8'hFF;
   localparam logic [7:0] ByteFd     = 8'hFD;
   localparam logic [7:0] ByteZero   = 8'h00;
   localparam logic [7:0] InstStatus = 8'h55;
   localparam logic [23:0] StuffMark = 24'hFFFFFD;

   localparam logic OpByte = 1'b0;
   localparam logic OpTick = 1'b1;

   localparam logic [1:0] KindParam  = 2'd0;
   localparam logic [1:0] KindGood   = 2'd1;
   localparam logic [1:0] KindCrcBad = 2'd2;
   localparam logic [1:0] KindResync = 2'd3;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic [CsrAddrWidth-3:0] CsrTimeoutIdx = '0;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  data_byte;
      logic [9:0]  byte_position;
      logic [7:0]  device_id;
      logic [7:0]  instruction;
      logic [7:0]  error_code;
      logic        is_status;
      logic [10:0] param_count;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_push_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

endpackage

[design/sprcrc16_csr.sv]
module sprcrc16_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [sprcrc16_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [sprcrc16_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [sprcrc16_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                    pready,
   output logic [15:0]                             timeout_ms
);

   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic        hit;

   assign pready = 1'b1;
   assign hit    = (paddr[sprcrc16_pkg::CsrAddrWidth-1:2] == sprcrc16_pkg::CsrTimeoutIdx);

   always_comb begin
      timeout_in = timeout_ff;
      if (psel && penable && pwrite && pready && hit) begin
         timeout_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= sprcrc16_pkg::TimeoutReset;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign prdata     = hit ? {{(sprcrc16_pkg::CsrDataWidth-16){1'b0}}, timeout_ff} : '0;
   assign timeout_ms = timeout_ff;

endmodule

[design/sprcrc16_parser.sv]
`include "stuffed_packet_receiver_crc16_defines.svh"

module sprcrc16_parser #(
   parameter int unsigned MAX_PARAM = sprcrc16_pkg::MaxParamDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sprcrc16_pkg::req_item_type req_item,
   input  logic [15:0]                timeout_ms,
   input  logic                       space,
   output sprcrc16_pkg::rsp_push_type push
);

   localparam int unsigned PW = $clog2(MAX_PARAM + 1);

   localparam logic [3:0] StH1    = 4'd0;
   localparam logic [3:0] StH2    = 4'd1;
   localparam logic [3:0] StH3    = 4'd2;
   localparam logic [3:0] StRsv   = 4'd3;
   localparam logic [3:0] StId    = 4'd4;
   localparam logic [3:0] StL1    = 4'd5;
   localparam logic [3:0] StL2    = 4'd6;
   localparam logic [3:0] StInst  = 4'd7;
   localparam logic [3:0] StErr   = 4'd8;
   localparam logic [3:0] StParam = 4'd9;
   localparam logic [3:0] StCrcL  = 4'd10;
   localparam logic [3:0] StCrcH  = 4'd11;

   logic                       in_valid_ff, in_valid_in;
   sprcrc16_pkg::req_item_type in_item_ff, in_item_in;
   logic [3:0]                 state_ff, state_in;
   logic [15:0]                crc_ff, crc_in;
   logic [15:0]                len_ff, len_in;
   logic [PW-1:0]              remain_ff, remain_in;
   logic [PW-1:0]              written_ff, written_in;
   logic [7:0]                 id_ff, id_in;
   logic [7:0]                 inst_ff, inst_in;
   logic [7:0]                 err_ff, err_in;
   logic                       status_ff, status_in;
   logic [23:0]                recent_ff, recent_in;
   logic [7:0]                 crc_low_ff, crc_low_in;
   logic [15:0]                idle_ff, idle_in;

   logic          advance;
   logic [7:0]    b;
   logic [3:0]    cur;
   logic [15:0]   crc_next;
   logic [16:0]   need;
   logic [16:0]   len_diff;
   logic [PW-1:0] remain_dec;
   logic          res_valid;
   logic [1:0]    res_kind;
   logic [7:0]    res_data;
   logic [PW-1:0] res_pos;
   logic [PW-1:0] res_count;
   logic [PW+10:0] pos_wide;
   logic [PW+10:0] count_wide;

   assign advance   = in_valid_ff && space;
   assign req_ready = !in_valid_ff || advance;
   assign b         = in_item_ff.rx_byte;
   assign crc_next  = sprcrc16_pkg::crc16_byte(crc_ff, b);
   assign need      = (b == sprcrc16_pkg::InstStatus) ? 17'd4 : 17'd3;
   assign len_diff  = {1'b0, len_ff} - need;
   assign remain_dec = (remain_ff != '0) ? remain_ff - PW'(1) : remain_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end
   end

   always_comb begin
      state_in   = state_ff;
      crc_in     = crc_ff;
      len_in     = len_ff;
      remain_in  = remain_ff;
      written_in = written_ff;
      id_in      = id_ff;
      inst_in    = inst_ff;
      err_in     = err_ff;
      status_in  = status_ff;
      recent_in  = recent_ff;
      crc_low_in = crc_low_ff;
      idle_in    = idle_ff;
      res_valid  = 1'b0;
      res_kind   = sprcrc16_pkg::KindParam;
      res_data   = 8'h00;
      res_pos    = '0;
      res_count  = '0;
      cur        = (idle_ff >= timeout_ms) ? StH1 : state_ff;
      if (advance && in_item_ff.opcode == sprcrc16_pkg::OpTick) begin
         if (idle_ff != 16'hFFFF) begin
            idle_in = idle_ff + 16'd1;
         end
      end else if (advance) begin
         idle_in = 16'd0;
         case (cur)
            StH2: begin
               state_in = (b == sprcrc16_pkg::ByteFf) ? StH3 : StH1;
               if (b == sprcrc16_pkg::ByteFf) begin
                  crc_in = crc_next;
               end
            end
            StH3: begin
               state_in = (b == sprcrc16_pkg::ByteFd) ? StRsv : StH1;
               if (b == sprcrc16_pkg::ByteFd) begin
                  crc_in = crc_next;
               end
            end
            StRsv: begin
               state_in = (b == sprcrc16_pkg::ByteZero) ? StId : StH1;
               if (b == sprcrc16_pkg::ByteZero) begin
                  crc_in = crc_next;
               end
            end
            StId: begin
               id_in    = b;
               crc_in   = crc_next;
               state_in = StL1;
            end
            StL1: begin
               len_in   = {8'h00, b};
               crc_in   = crc_next;
               state_in = StL2;
            end
            StL2: begin
               len_in   = {b, len_ff[7:0]};
               crc_in   = crc_next;
               state_in = StInst;
            end
            StInst: begin
               crc_in     = crc_next;
               inst_in    = b;
               err_in     = 8'h00;
               written_in = '0;
               recent_in  = {16'h0000, b};
               status_in  = (b == sprcrc16_pkg::InstStatus);
               if ({1'b0, len_ff} < need || len_diff > 17'(MAX_PARAM)) begin
                  state_in  = StH1;
                  res_valid = 1'b1;
                  res_kind  = sprcrc16_pkg::KindResync;
               end else begin
                  remain_in = len_diff[PW-1:0];
                  if (b == sprcrc16_pkg::InstStatus) begin
                     state_in = StErr;
                  end else begin
                     state_in = (len_diff != '0) ? StParam : StCrcL;
                  end
               end
            end
            StErr: begin
               crc_in    = crc_next;
               err_in    = b;
               recent_in = {recent_ff[15:0], b};
               state_in  = (remain_ff != '0) ? StParam : StCrcL;
            end
            StParam: begin
               crc_in    = crc_next;
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  state_in = StCrcL;
               end
               if (!(b == sprcrc16_pkg::ByteFd && recent_ff == sprcrc16_pkg::StuffMark)) begin
                  recent_in  = {recent_ff[15:0], b};
                  written_in = written_ff + PW'(1);
                  res_valid  = 1'b1;
                  res_kind   = sprcrc16_pkg::KindParam;
                  res_data   = b;
                  res_pos    = written_ff;
               end
            end
            StCrcL: begin
               crc_low_in = b;
               state_in   = StCrcH;
            end
            StCrcH: begin
               state_in  = StH1;
               res_valid = 1'b1;
               res_kind  = ({b, crc_low_ff} == crc_ff) ? sprcrc16_pkg::KindGood
                                                       : sprcrc16_pkg::KindCrcBad;
               res_count = written_ff;
            end
            default: begin
               if (b == sprcrc16_pkg::ByteFf) begin
                  crc_in   = sprcrc16_pkg::crc16_byte(16'h0000, b);
                  state_in = StH2;
               end else begin
                  state_in = StH1;
               end
            end
         endcase
      end
   end

   assign pos_wide   = {11'b0, res_pos};
   assign count_wide = {11'b0, res_count};

   always_comb begin
      push.valid              = res_valid;
      push.item.result_kind   = res_kind;
      push.item.data_byte     = res_data;
      push.item.byte_position = pos_wide[9:0];
      push.item.device_id     = id_in;
      push.item.instruction   = inst_in;
      push.item.error_code    = status_in ? err_in : 8'h00;
      push.item.is_status     = status_in;
      push.item.param_count   = count_wide[10:0];
      push.item.last          = (res_kind != sprcrc16_pkg::KindParam);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= StH1;
         crc_ff      <= '0;
         len_ff      <= '0;
         remain_ff   <= '0;
         written_ff  <= '0;
         id_ff       <= '0;
         inst_ff     <= '0;
         err_ff      <= '0;
         status_ff   <= 1'b0;
         recent_ff   <= '0;
         crc_low_ff  <= '0;
         idle_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         crc_ff      <= crc_in;
         len_ff      <= len_in;
         remain_ff   <= remain_in;
         written_ff  <= written_in;
         id_ff       <= id_in;
         inst_ff     <= inst_in;
         err_ff      <= err_in;
         status_ff   <= status_in;
         recent_ff   <= recent_in;
         crc_low_ff  <= crc_low_in;
         idle_ff     <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   `SPRC_ASSERT_NEXT(a_stall_holds, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_item_ff))
   `SPRC_ASSERT_NEXT(a_end_to_hunt, clock, reset, advance && push.valid && push.item.last, state_ff == StH1)
   `SPRC_ASSERT_NOW(a_remain_bound, clock, reset, 1'b1, {1'b0, remain_ff} <= (PW+1)'(MAX_PARAM))

endmodule

[design/sprcrc16_outbuf.sv]
`include "stuffed_packet_receiver_crc16_defines.svh"

module sprcrc16_outbuf (
   input  logic                       clock,
   input  logic                       reset,
   input  sprcrc16_pkg::rsp_push_type push,
   output logic                       space,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sprcrc16_pkg::rsp_item_type rsp_item
);

   sprcrc16_pkg::rsp_item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   `SPRC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= 2'd2)
   `SPRC_ASSERT_NOW(a_no_overflow, clock, reset, push.valid, count_ff != 2'd2)
   `SPRC_ASSERT_NEXT(a_count_grows, clock, reset, push.valid && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

[design/stuffed_packet_receiver_crc16.sv]
// Byte-stuffed packet receiver with CRC-16 check.
// req channel: one item per handshake, either a received byte (opcode 0) or a
//   one millisecond tick (opcode 1). Ticks advance the idle counter only.
// rsp channel: one item per parameter byte (destuffed, with its position) and
//   one item with last set at packet end (CRC good, CRC mismatch) or when a
//   bad length forces a resync.
// csr port: APB-style, timeout_ms at byte address 0, reset value 100.
// Result path: an accepted byte waits in the input register, is parsed, and its result
//   is written to the result buffer, which presents it on rsp; a full buffer holds it back.
// Throughput: one item per cycle while the result buffer has space, set by the
//   combinational parse and CRC update from input register to two-entry result buffer.
// Reset: synchronous; parsing restarts at header hunt, the CRC, counters and
//   held packet fields clear, and the result buffer empties.
// Receiver stall: the result buffer holds up to two items; when it is full the
//   input register holds its item and req_ready drops until rsp drains.
module stuffed_packet_receiver_crc16 #(
   parameter int unsigned MAX_PARAM = sprcrc16_pkg::MaxParamDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sprcrc16_pkg::req_item_type            req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sprcrc16_pkg::rsp_item_type            rsp_item,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [sprcrc16_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [sprcrc16_pkg::CsrDataWidth-1:0] pwdata,
   output logic [sprcrc16_pkg::CsrDataWidth-1:0] prdata,
   output logic                                  pready
);

   logic [15:0]                timeout_ms;
   logic                       space;
   sprcrc16_pkg::rsp_push_type push;

   sprcrc16_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .timeout_ms (timeout_ms)
   );

   sprcrc16_parser #(
      .MAX_PARAM (MAX_PARAM)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .timeout_ms (timeout_ms),
      .space      (space),
      .push       (push)
   );

   sprcrc16_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

[tb/tb_stuffed_packet_receiver_crc16.sv]
module tb_stuffed_packet_receiver_crc16;
   timeunit 1ns;
   timeprecision 1ps;

   import sprcrc16_pkg::*;

   localparam int StallLimit    = 4000;
   localparam int DrainCycles   = 4;
   localparam int ItemsPerPhase = 250;

   typedef enum logic [3:0] {
      HUNT_FF1, HUNT_FF2, HUNT_FD, HUNT_RSV, GET_ID, GET_LEN_LO, GET_LEN_HI,
      GET_INST, GET_ERR, GET_PARAM, GET_CRC_LO, GET_CRC_HI
   } parse_phase_e;

   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_item_type            req_item  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_item_type            rsp_item;
   logic                    psel      = 1'b0;
   logic                    penable   = 1'b0;
   logic                    pwrite    = 1'b0;
   logic [CsrAddrWidth-1:0] paddr     = '0;
   logic [CsrDataWidth-1:0] pwdata    = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   // deframer prediction state
   logic [15:0]  timeout_ticks = TimeoutReset;
   parse_phase_e parse_phase   = HUNT_FF1;
   logic [15:0]  crc_run       = '0;
   logic [15:0]  len_field     = '0;
   int           params_left   = 0;
   logic [15:0]  params_out    = '0;
   logic [7:0]   pkt_id        = '0;
   logic [7:0]   pkt_inst      = '0;
   logic [7:0]   pkt_err       = '0;
   logic         pkt_status    = 1'b0;
   logic [23:0]  tail3         = '0;
   logic [7:0]   crc_lo_held   = '0;
   logic [15:0]  idle_ticks    = '0;

   rsp_item_type pending_results[$];
   logic [7:0]   frame_q[$];
   logic [7:0]   param_q[$];

   int send_gap_pct      = 0;
   int rsp_stall_pct     = 0;
   int tick_in_frame_pct = 0;
   int error_count       = 0;
   int items_sent        = 0;
   int ticks_sent        = 0;
   int seen_param        = 0;
   int seen_good         = 0;
   int seen_crc_bad      = 0;
   int seen_resync       = 0;
   int quiet_cycles      = 0;

   stuffed_packet_receiver_crc16 i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0};
         if (fb) c = c ^ CrcPoly;
      end
      return c;
   endfunction

   task automatic deframe_step(input req_item_type it);
      logic [7:0]   b;
      logic [15:0]  pos;
      logic [15:0]  got;
      logic         drop;
      int           need;
      bit           has_result;
      rsp_item_type r;
      b          = it.rx_byte;
      has_result = 1'b0;
      r          = '0;
      if (it.opcode == OpTick) begin
         if (idle_ticks != 16'hFFFF) idle_ticks++;
         return;
      end
      if (idle_ticks >= timeout_ticks) parse_phase = HUNT_FF1;
      idle_ticks = '0;
      case (parse_phase)
         HUNT_FF2: begin
            if (b == ByteFf) begin
               crc_run     = crc16_next(crc_run, b);
               parse_phase = HUNT_FD;
            end else begin
               parse_phase = HUNT_FF1;
            end
         end
         HUNT_FD: begin
            if (b == ByteFd) begin
               crc_run     = crc16_next(crc_run, b);
               parse_phase = HUNT_RSV;
            end else begin
               parse_phase = HUNT_FF1;
            end
         end
         HUNT_RSV: begin
            if (b == ByteZero) begin
               crc_run     = crc16_next(crc_run, b);
               parse_phase = GET_ID;
            end else begin
               parse_phase = HUNT_FF1;
            end
         end
         GET_ID: begin
            pkt_id      = b;
            crc_run     = crc16_next(crc_run, b);
            parse_phase = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            len_field   = {8'h00, b};
            crc_run     = crc16_next(crc_run, b);
            parse_phase = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            len_field   = {b, len_field[7:0]};
            crc_run     = crc16_next(crc_run, b);
            parse_phase = GET_INST;
         end
         GET_INST: begin
            crc_run    = crc16_next(crc_run, b);
            pkt_inst   = b;
            pkt_err    = '0;
            params_out = '0;
            tail3      = {16'h0000, b};
            pkt_status = (b == InstStatus);
            need       = pkt_status ? 4 : 3;
            if (int'(len_field) < need ||
                int'(len_field) - need > int'(MaxParamDefault)) begin
               parse_phase   = HUNT_FF1;
               has_result    = 1'b1;
               r.result_kind = KindResync;
               r.last        = 1'b1;
            end else begin
               params_left = int'(len_field) - need;
               if (pkt_status) parse_phase = GET_ERR;
               else parse_phase = (params_left != 0) ? GET_PARAM : GET_CRC_LO;
            end
         end
         GET_ERR: begin
            crc_run     = crc16_next(crc_run, b);
            pkt_err     = b;
            tail3       = {tail3[15:0], b};
            parse_phase = (params_left != 0) ? GET_PARAM : GET_CRC_LO;
         end
         GET_PARAM: begin
            pos     = params_out;
            drop    = (b == ByteFd) && (tail3 == StuffMark);
            crc_run = crc16_next(crc_run, b);
            if (params_left != 0) params_left--;
            if (params_left == 0) parse_phase = GET_CRC_LO;
            if (!drop) begin
               tail3           = {tail3[15:0], b};
               params_out      = params_out + 16'd1;
               has_result      = 1'b1;
               r.result_kind   = KindParam;
               r.data_byte     = b;
               r.byte_position = pos[9:0];
            end
         end
         GET_CRC_LO: begin
            crc_lo_held = b;
            parse_phase = GET_CRC_HI;
         end
         GET_CRC_HI: begin
            got           = {b, crc_lo_held};
            parse_phase   = HUNT_FF1;
            has_result    = 1'b1;
            r.result_kind = (got == crc_run) ? KindGood : KindCrcBad;
            r.param_count = params_out[10:0];
            r.last        = 1'b1;
         end
         default: begin
            if (b == ByteFf) begin
               crc_run     = crc16_next(16'h0000, b);
               parse_phase = HUNT_FF2;
            end else begin
               parse_phase = HUNT_FF1;
            end
         end
      endcase
      if (has_result) begin
         r.device_id   = pkt_id;
         r.instruction = pkt_inst;
         r.error_code  = pkt_status ? pkt_err : 8'h00;
         r.is_status   = pkt_status;
         pending_results.push_back(r);
      end
   endtask

   task automatic push_item(input req_item_type it);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      deframe_step(it);
      items_sent++;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) begin
         push_item({OpTick, 8'($urandom_range(255))});
         ticks_sent++;
      end
   endtask

   task automatic send_frame(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < tick_in_frame_pct) send_ticks($urandom_range(2, 1));
         push_item({OpByte, frame_q[i]});
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [15:0] wval,
                             output logic [31:0] rval);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {CsrTimeoutIdx, 2'b00};
      pwdata  <= {16'h0000, wval};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rval = prdata;
      if (write) timeout_ticks = wval;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_timeout_reg(input logic [15:0] want);
      logic [31:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd[15:0] !== want) begin
         $display("%0t ns: timeout_ms read expected %0d got %0d", $time, want, rd[15:0]);
         error_count++;
      end
   endtask

   task automatic set_timeout(input logic [15:0] value);
      logic [31:0] rd;
      csr_access(1'b1, value, rd);
      check_timeout_reg(value);
   endtask

   function automatic logic [7:0] noise_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 25) return ByteFf;
      if (pick < 40) return ByteFd;
      if (pick < 45) return ByteZero;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [15:0] frame_len(input logic [7:0] inst);
      return 16'(3 + int'(inst == InstStatus) + param_q.size());
   endfunction

   task automatic fill_params(input int n);
      param_q.delete();
      while (param_q.size() < n) begin
         if (n - param_q.size() >= 4 && $urandom_range(9) == 0) begin
            param_q.push_back(ByteFf);
            param_q.push_back(ByteFf);
            param_q.push_back(ByteFd);
            param_q.push_back(($urandom_range(9) < 7) ? ByteFd : 8'($urandom_range(255)));
         end else begin
            param_q.push_back(noise_byte());
         end
      end
   endtask

   task automatic assemble_frame(input logic [7:0] id, input logic [7:0] inst,
                                 input logic [7:0] err, input logic [15:0] len,
                                 input bit crc_ok);
      logic [15:0] crc;
      int          flip;
      frame_q = {ByteFf, ByteFf, ByteFd, ByteZero, id, len[7:0], len[15:8], inst};
      if (inst == InstStatus) frame_q.push_back(err);
      foreach (param_q[i]) frame_q.push_back(param_q[i]);
      crc = '0;
      foreach (frame_q[i]) crc = crc16_next(crc, frame_q[i]);
      flip = $urandom_range(15);
      if (!crc_ok) crc[flip] = ~crc[flip];
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
   endtask

   task automatic test_register_access();
      check_timeout_reg(TimeoutReset);
      set_timeout(16'hFFFF);
      set_timeout(TimeoutReset);
   endtask

   task automatic test_stuffed_status();
      param_q = {ByteFf, ByteFd, ByteFd, 8'h7E};
      assemble_frame(8'h01, InstStatus, 8'hFF, frame_len(InstStatus), 1'b1);
      send_frame(frame_q.size());
      settle();
   endtask

   task automatic test_empty_frame_bad_crc();
      param_q.delete();
      assemble_frame(8'h00, 8'h00, 8'h00, frame_len(8'h00), 1'b0);
      send_frame(frame_q.size());
      settle();
   endtask

   task automatic test_length_out_of_range();
      param_q.delete();
      assemble_frame(8'hFF, InstStatus, 8'h00, 16'hFFFF, 1'b1);
      send_frame(8);
      assemble_frame(8'h7F, InstStatus, 8'h00, 16'd3, 1'b1);
      send_frame(8);
      settle();
   endtask

   task automatic test_timeout_restart();
      set_timeout(16'd1);
      param_q = {8'h00};
      assemble_frame(8'h02, 8'h03, 8'h00, frame_len(8'h03), 1'b1);
      send_frame(7);
      send_ticks(1);
      param_q.delete();
      assemble_frame(8'h03, 8'h04, 8'h00, frame_len(8'h04), 1'b1);
      send_frame(frame_q.size());
      settle();
   endtask

   task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                      input logic [15:0] timeout, input int n_items);
      int          stop_at;
      int          sel;
      int          need;
      logic [7:0]  inst;
      logic [15:0] len;
      send_gap_pct      = gap_pct;
      rsp_stall_pct     = stall_pct;
      tick_in_frame_pct = 2;
      set_timeout(timeout);
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         sel = $urandom_range(99);
         if (sel < 25) inst = InstStatus;
         else if (sel < 35) inst = ByteFf;
         else inst = 8'($urandom_range(255));
         need = (inst == InstStatus) ? 4 : 3;
         fill_params(($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(40, 13));
         sel = $urandom_range(99);
         if (sel < 65) begin
            assemble_frame(8'($urandom_range(255)), inst, 8'($urandom_range(255)),
                           frame_len(inst), $urandom_range(99) < 85);
            send_frame(frame_q.size());
         end else if (sel < 75) begin
            case ($urandom_range(4))
               0: len = '0;
               1: len = 16'(need - 1);
               2: len = 16'(int'(MaxParamDefault) + need + 1);
               3: len = 16'hFFFF;
               default: len = 16'($urandom_range(65535, int'(MaxParamDefault) + need + 1));
            endcase
            assemble_frame(8'($urandom_range(255)), inst, 8'($urandom_range(255)), len, 1'b1);
            send_frame(frame_q.size());
         end else if (sel < 83) begin
            // cut short; the largest legal length only where ticks can abort it
            len = frame_len(inst);
            if (timeout_ticks <= 8 && $urandom_range(1) == 1)
               len = 16'(int'(MaxParamDefault) + need);
            assemble_frame(8'($urandom_range(255)), inst, 8'($urandom_range(255)), len, 1'b1);
            send_frame($urandom_range(frame_q.size() - 1, 1));
            if (timeout_ticks <= 8) send_ticks(timeout_ticks);
         end else if (sel < 93) begin
            repeat ($urandom_range(6, 1)) push_item({OpByte, noise_byte()});
         end else begin
            send_ticks($urandom_range((timeout_ticks < 12) ? timeout_ticks + 1 : 12, 1));
         end
      end
      settle();
   endtask

   task automatic check_field(input string what, input logic [10:0] want,
                              input logic [10:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         case (rsp_item.result_kind)
            KindParam:  seen_param++;
            KindGood:   seen_good++;
            KindCrcBad: seen_crc_bad++;
            KindResync: seen_resync++;
         endcase
         if (pending_results.size() == 0) begin
            $display("%0t ns: result expected none got %p", $time, rsp_item);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", want.result_kind, rsp_item.result_kind);
            check_field("data_byte", want.data_byte, rsp_item.data_byte);
            check_field("byte_position", want.byte_position, rsp_item.byte_position);
            check_field("device_id", want.device_id, rsp_item.device_id);
            check_field("instruction", want.instruction, rsp_item.instruction);
            check_field("error_code", want.error_code, rsp_item.error_code);
            check_field("is_status", want.is_status, rsp_item.is_status);
            check_field("param_count", want.param_count, rsp_item.param_count);
            check_field("last", want.last, rsp_item.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("%0t ns: no item moved for %0d cycles", $time, quiet_cycles);
         $display("tb_stuffed_packet_receiver_crc16: errors");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_stuffed_status();
      test_empty_frame_bad_crc();
      test_length_out_of_range();
      test_timeout_restart();
      test_random_traffic(16, 77, 16'($urandom_range(6, 2)), ItemsPerPhase);
      test_random_traffic(77, 16, 16'hFFFF, ItemsPerPhase);
      test_random_traffic(0, 0, 16'd1, ItemsPerPhase);
      $display("sent %0d items (%0d ticks): directed frames, then three stall/timeout mixes",
               items_sent, ticks_sent);
      $display("saw %0d parameter bytes, %0d good frames, %0d crc mismatches, %0d resyncs",
               seen_param, seen_good, seen_crc_bad, seen_resync);
      if (error_count == 0) begin
         $display("tb_stuffed_packet_receiver_crc16: clean");
      end else begin
         $display("tb_stuffed_packet_receiver_crc16: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/sprcrc16_pkg.sv
design/sprcrc16_csr.sv
design/sprcrc16_parser.sv
design/sprcrc16_outbuf.sv
design/stuffed_packet_receiver_crc16.sv
tb/tb_stuffed_packet_receiver_crc16.sv
